/* rtl/frie_pkg.sv */
// ----------------------------------------------------------------------------
// frie_pkg: shared types and constants of the fuzzy rule inference engine
// holds action codes, trapezoid kinds, fixed-point constants and the
// command/status structs between controller and datapath
// ----------------------------------------------------------------------------
package frie_pkg;

   // action codes
   localparam logic [1:0] ACT_WR_MEMBER    = 2'd0;
   localparam logic [1:0] ACT_WR_RULE      = 2'd1;
   localparam logic [1:0] ACT_WR_SINGLETON = 2'd2;
   localparam logic [1:0] ACT_EVALUATE     = 2'd3;

   // trapezoid kinds
   localparam logic [1:0] KIND_REGULAR = 2'd0;
   localparam logic [1:0] KIND_LEFT    = 2'd1;
   localparam logic [1:0] KIND_RIGHT   = 2'd2;

   localparam int VARIABLES       = 4;
   localparam int SINGLETON_DEPTH = 16;
   localparam logic [15:0] ONE_Q15 = 16'h8000;

   // accumulator widths
   localparam int NUM_W = 40;
   localparam int DEN_W = 26;

   // controller commands
   typedef struct packed {
      logic capture;     // latch input word
      logic do_write;    // perform table write
      logic clear_acc;   // clear accumulators
      logic issue_read;  // read rule table for rule_idx
      logic read_mem;    // read membership/singleton for the fetched rule
      logic compute;     // compute degrees
      logic accumulate;  // add products to accumulators
      logic div_start;   // start divider
      logic finish;      // load result register
   } cmd_type;

   // datapath status
   typedef struct packed {
      logic div_done;
   } status_type;

endpackage

/* rtl/fuzzy_rule_inference_engine_core.sv */
// ----------------------------------------------------------------------------
// fuzzy_rule_inference_engine_core: zero-order sugeno fuzzy controller
// table loading, rule walk, weighted average with one result word per request
// ----------------------------------------------------------------------------
// Each request word gives one response word. Table writes pass through a
// write state that waits for a free response register, then writes the
// table and loads the response. An evaluation walks rule_count rules
// (capped at MAX_RULES) through a four-stage read/degree/accumulate pipeline
// at one rule a cycle, then runs a bit-serial divider. One request is in
// work at a time; the response register lets the next request be taken
// while a response waits.
module fuzzy_rule_inference_engine_core
   import frie_pkg::*;
#(
   parameter int MAX_RULES         = 64,
   parameter int ANTECEDENTS       = 2,
   parameter int SETS_PER_VARIABLE = 5,
   parameter int SINGLETONS        = 9
) (
   input  logic         clock,
   input  logic         reset,
   // action, index, point_a..point_d, slope_left, slope_right, kind
   input  logic [111:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // control_value
   output logic [15:0]  rsp_tdata,
   // zero_weight
   output logic         rsp_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [6:0]   csr_data,
   input  logic         csr_valid,
   output logic         csr_ready
);

   cmd_type    cmd;
   status_type status;
   logic [$clog2(MAX_RULES)-1:0] rule_idx;
   logic [6:0]         rule_count_ff;
   logic signed [15:0] res_value;
   logic               res_zero;
   logic               out_busy;

   // rule count register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         rule_count_ff <= 7'd50;
      end else if (csr_valid) begin
         rule_count_ff <= csr_data;
      end
   end

   assign out_busy = rsp_tvalid && !rsp_tready;

   frie_ctrl #(.MAX_RULES(MAX_RULES)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tdata[1:0]),
      .out_busy   (out_busy),
      .rule_count (rule_count_ff),
      .status     (status),
      .cmd        (cmd),
      .rule_idx   (rule_idx)
   );

   frie_dp #(
      .MAX_RULES         (MAX_RULES),
      .ANTECEDENTS       (ANTECEDENTS),
      .SETS_PER_VARIABLE (SETS_PER_VARIABLE),
      .SINGLETONS        (SINGLETONS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .rule_idx        (rule_idx),
      .req_action      (req_tdata[1:0]),
      .req_index       (req_tdata[7:2]),
      .req_point_a     (req_tdata[23:8]),
      .req_point_b     (req_tdata[39:24]),
      .req_point_c     (req_tdata[55:40]),
      .req_point_d     (req_tdata[71:56]),
      .req_slope_left  (req_tdata[87:72]),
      .req_slope_right (req_tdata[103:88]),
      .req_kind        (req_tdata[107:104]),
      .res_value       (res_value),
      .res_zero        (res_zero)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (cmd.finish) begin
         rsp_tvalid <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_tdata <= res_value;
         rsp_tuser <= res_zero;
      end
   end

`ifndef ASSERT_OFF
   // a response is never overwritten while stalled
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !cmd.finish)
      else $error("response overwritten");
   // zero flag only with zero value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 16'd0))
      else $error("zero flag with nonzero value");
   // request accept starts work in datapath
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> cmd.capture)
      else $error("accept without capture");
`endif

endmodule

/* rtl/frie_ram.sv */
// ----------------------------------------------------------------------------
// frie_ram: generic single-port-write, single-port-read ram
// registered read data
// ----------------------------------------------------------------------------
module frie_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* rtl/frie_ctrl.sv */
// ----------------------------------------------------------------------------
// frie_ctrl: controller of the fuzzy rule inference engine
// sequences table writes and the rule walk, division and result hand-off
// ----------------------------------------------------------------------------
module frie_ctrl
   import frie_pkg::*;
#(
   parameter int MAX_RULES = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [1:0]                   req_action,
   input  logic                         out_busy,
   input  logic [6:0]                   rule_count,
   input  status_type                   status,
   output cmd_type                      cmd,
   output logic [$clog2(MAX_RULES)-1:0] rule_idx
);

   localparam int IW = $clog2(MAX_RULES);
   localparam int CW = $clog2(MAX_RULES + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_WRITE = 3'd1;
   localparam logic [2:0] ST_RULE  = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] issue_ff, issue_in;   // rules issued
   logic [3:0]    pipe_ff, pipe_in;     // valid bits of the rule pipeline
   logic [CW-1:0] limit;
   logic          accepted;
   logic          issue_now;

   assign req_tready = (state_ff == ST_IDLE);
   assign accepted   = req_tvalid && req_tready;

   // clamp rule count
   always_comb begin
      if (32'(rule_count) > MAX_RULES) begin
         limit = CW'(MAX_RULES);
      end else begin
         limit = CW'(rule_count);
      end
   end

   assign issue_now = (state_ff == ST_RULE) && (issue_ff < limit);
   assign rule_idx  = issue_ff[IW-1:0];

   // next state and commands
   always_comb begin
      state_in = state_ff;
      issue_in = issue_ff;
      pipe_in  = {pipe_ff[2:0], issue_now};
      cmd      = '0;
      cmd.issue_read = issue_now;
      cmd.read_mem   = pipe_ff[0];
      cmd.compute    = pipe_ff[1];
      cmd.accumulate = pipe_ff[2];
      case (state_ff)
         ST_IDLE: begin
            if (accepted) begin
               cmd.capture   = 1'b1;
               cmd.clear_acc = 1'b1;
               issue_in      = '0;
               if (req_action == ACT_EVALUATE) begin
                  state_in = ST_RULE;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            if (!out_busy) begin
               cmd.do_write = 1'b1;
               cmd.finish   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_RULE: begin
            if (issue_now) begin
               issue_in = issue_ff + 1'b1;
            end else if (pipe_ff == '0) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         issue_ff <= '0;
         pipe_ff  <= '0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
         pipe_ff  <= pipe_in;
      end
   end

`ifndef ASSERT_OFF
   // rule pipeline only runs during the rule walk
   assert property (@(posedge clock) disable iff (reset)
      (pipe_ff != '0) |-> (state_ff == ST_RULE))
      else $error("rule pipeline active outside rule walk");
   // issue count never passes the clamped rule count
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RULE) |-> (issue_ff <= limit))
      else $error("rule issue overran rule count");
   // divider start leads into divide state
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> (state_ff == ST_DIV))
      else $error("divider started without divide state");
`endif

endmodule

/* rtl/frie_dp.sv */
// ----------------------------------------------------------------------------
// frie_dp: datapath of the fuzzy rule inference engine
// table memories, trapezoid degree units, accumulators and a restoring divider
// ----------------------------------------------------------------------------
module frie_dp
   import frie_pkg::*;
#(
   parameter int MAX_RULES         = 64,
   parameter int ANTECEDENTS       = 2,
   parameter int SETS_PER_VARIABLE = 5,
   parameter int SINGLETONS        = 9
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output status_type                   status,
   input  logic [$clog2(MAX_RULES)-1:0] rule_idx,
   input  logic [1:0]                   req_action,
   input  logic [5:0]                   req_index,
   input  logic signed [15:0]           req_point_a,
   input  logic signed [15:0]           req_point_b,
   input  logic signed [15:0]           req_point_c,
   input  logic signed [15:0]           req_point_d,
   input  logic signed [15:0]           req_slope_left,
   input  logic signed [15:0]           req_slope_right,
   input  logic [3:0]                   req_kind,
   output logic signed [15:0]           res_value,
   output logic                         res_zero
);

   localparam int MEM_DEPTH = VARIABLES * SETS_PER_VARIABLE;
   localparam int MW  = $clog2(MEM_DEPTH);
   localparam int RW  = $clog2(MAX_RULES);
   localparam int ANTS = (ANTECEDENTS > 2) ? 2 : ANTECEDENTS;

   // captured input word
   logic [1:0]         act_ff;
   logic [5:0]         idx_ff;
   logic signed [15:0] pa_ff, pb_ff, pc_ff, pd_ff, sl_ff, sr_ff;
   logic [3:0]         kind_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff  <= req_action;
         idx_ff  <= req_index;
         pa_ff   <= req_point_a;
         pb_ff   <= req_point_b;
         pc_ff   <= req_point_c;
         pd_ff   <= req_point_d;
         sl_ff   <= req_slope_left;
         sr_ff   <= req_slope_right;
         kind_ff <= req_kind;
      end
   end

   // write enables
   logic we_mem, we_rule, we_sing;
   assign we_mem  = cmd.do_write && (act_ff == ACT_WR_MEMBER) && (32'(idx_ff) < MEM_DEPTH);
   assign we_rule = cmd.do_write && (act_ff == ACT_WR_RULE) && (32'(idx_ff) < MAX_RULES);
   assign we_sing = cmd.do_write && (act_ff == ACT_WR_SINGLETON)
                    && (32'(idx_ff) < SINGLETONS);

   // rule table: {cons, set1, var1, set0, var0}
   logic [13:0] rule_rd;
   frie_ram #(.WIDTH(14), .DEPTH(MAX_RULES)) u_rule (
      .clock   (clock),
      .wr_en   (we_rule),
      .wr_addr (RW'(idx_ff)),
      .wr_data ({kind_ff, pd_ff[2:0], pc_ff[1:0], pb_ff[2:0], pa_ff[1:0]}),
      .rd_addr (rule_idx),
      .rd_data (rule_rd)
   );

   // singleton table
   logic [15:0] sing_rd;
   frie_ram #(.WIDTH(16), .DEPTH(SINGLETON_DEPTH)) u_sing (
      .clock   (clock),
      .wr_en   (we_sing),
      .wr_addr (idx_ff[3:0]),
      .wr_data (pa_ff),
      .rd_addr (rule_rd[13:10]),
      .rd_data (sing_rd)
   );

   // fetched rule fields
   logic [1:0] var_sel [2];
   logic [2:0] set_sel [2];
   assign var_sel[0] = rule_rd[1:0];
   assign set_sel[0] = rule_rd[4:2];
   assign var_sel[1] = rule_rd[6:5];
   assign set_sel[1] = rule_rd[9:7];

   // stage after the rule read: validity of each antecedent and consequent
   logic       ant_ok_ff [2];
   logic       cons_ok_ff;

   always_ff @(posedge clock) begin
      if (cmd.read_mem) begin
         for (int j = 0; j < 2; j++) begin
            ant_ok_ff[j] <= (32'(set_sel[j]) < SETS_PER_VARIABLE);
         end
         cons_ok_ff <= (32'(rule_rd[13:10]) < SINGLETONS);
      end
   end

   // membership memories, one pair per antecedent
   logic [63:0] pts_rd [2];
   logic [33:0] slp_rd [2];
   logic [15:0] x_ff [2];

   for (genvar g = 0; g < 2; g++) begin : g_mem
      logic [MW-1:0] maddr;
      logic [5:0]    entry;
      assign entry = 6'(var_sel[g] * SETS_PER_VARIABLE) + 6'(set_sel[g]);
      assign maddr = entry[MW-1:0];

      frie_ram #(.WIDTH(64), .DEPTH(MEM_DEPTH)) u_pts (
         .clock   (clock),
         .wr_en   (we_mem),
         .wr_addr (idx_ff[MW-1:0]),
         .wr_data ({pd_ff, pc_ff, pb_ff, pa_ff}),
         .rd_addr (maddr),
         .rd_data (pts_rd[g])
      );
      frie_ram #(.WIDTH(34), .DEPTH(MEM_DEPTH)) u_slp (
         .clock   (clock),
         .wr_en   (we_mem),
         .wr_addr (idx_ff[MW-1:0]),
         .wr_data ({kind_ff[1:0], sr_ff, sl_ff}),
         .rd_addr (maddr),
         .rd_data (slp_rd[g])
      );
   end

   // pick input variable for each antecedent
   always_ff @(posedge clock) begin
      if (cmd.read_mem) begin
         for (int j = 0; j < 2; j++) begin
            case (var_sel[j])
               2'd0:    x_ff[j] <= pa_ff;
               2'd1:    x_ff[j] <= pb_ff;
               2'd2:    x_ff[j] <= pc_ff;
               default: x_ff[j] <= pd_ff;
            endcase
         end
      end
   end

   // trapezoid degree, one per antecedent
   logic [15:0] deg [2];
   logic [15:0] sv_ff;

   for (genvar g = 0; g < 2; g++) begin : g_deg
      logic signed [15:0] a, b, c, d, sl, sr, x;
      logic [1:0]         k;
      logic signed [15:0] slope;
      logic signed [16:0] diff;
      logic signed [32:0] prod;
      logic signed [30:0] shr;
      logic [1:0]         mode;   // 0 zero, 1 one, 2 sloped
      assign a  = pts_rd[g][15:0];
      assign b  = pts_rd[g][31:16];
      assign c  = pts_rd[g][47:32];
      assign d  = pts_rd[g][63:48];
      assign sl = slp_rd[g][15:0];
      assign sr = slp_rd[g][31:16];
      assign k  = slp_rd[g][33:32];
      assign x  = x_ff[g];

      always_comb begin
         mode  = 2'd0;
         slope = sl;
         diff  = 17'(x) - 17'(a);
         case (k)
            KIND_LEFT: begin
               if (x <= a) mode = 2'd1;
               else if (x >= b) mode = 2'd0;
               else begin
                  mode = 2'd2; slope = sr; diff = 17'(x) - 17'(b);
               end
            end
            KIND_RIGHT: begin
               if (x <= a) mode = 2'd0;
               else if (x >= b) mode = 2'd1;
               else mode = 2'd2;
            end
            KIND_REGULAR: begin
               if (x <= a || x >= d) mode = 2'd0;
               else if (x >= b && x <= c) mode = 2'd1;
               else if (x <= b) mode = 2'd2;
               else if (x >= c) begin
                  mode = 2'd2; slope = sr; diff = 17'(x) - 17'(d);
               end
            end
            default: mode = 2'd0;
         endcase
         prod = 33'(slope) * 33'(diff);
         shr  = prod[32:2];
         case (mode)
            2'd1: deg[g] = ONE_Q15;
            2'd2: begin
               if (prod <= 0) deg[g] = '0;
               else if (shr > 31'sd32768) deg[g] = ONE_Q15;
               else deg[g] = shr[15:0];
            end
            default: deg[g] = '0;
         endcase
         if (!ant_ok_ff[g]) deg[g] = '0;
      end
   end

   // weight and singleton value
   logic [15:0] w_ff;
   logic [15:0] w_next;
   always_comb begin
      w_next = deg[0];
      if (ANTS > 1 && deg[1] < deg[0]) w_next = deg[1];
   end

   always_ff @(posedge clock) begin
      if (cmd.compute) begin
         w_ff  <= w_next;
         sv_ff <= cons_ok_ff ? sing_rd : 16'd0;
      end
   end

   // accumulators
   logic signed [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0]        den_ff;
   logic signed [32:0]      wprod;
   assign wprod = $signed({1'b0, 16'(w_ff)}) * $signed({sv_ff[15], sv_ff});

   always_ff @(posedge clock) begin
      if (cmd.clear_acc) begin
         num_ff <= '0;
         den_ff <= '0;
      end else if (cmd.accumulate) begin
         num_ff <= num_ff + NUM_W'(wprod);
         den_ff <= den_ff + DEN_W'(w_ff);
      end
   end

   // restoring divider on magnitudes, one bit a cycle
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W:0]   rem_ff;
   logic [5:0]       cnt_ff;
   logic             busy_ff, neg_ff, done_ff;
   logic [NUM_W-1:0] nmag;
   logic [DEN_W:0]   trial;

   assign nmag  = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
   assign trial = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]} - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.div_start) begin
            busy_ff <= (den_ff != '0);
            done_ff <= (den_ff == '0);
         end else if (busy_ff && cnt_ff == 6'(NUM_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quo_ff <= nmag;
         rem_ff <= '0;
         cnt_ff <= '0;
         neg_ff <= num_ff[NUM_W-1];
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (!trial[DEN_W]) begin
            rem_ff <= trial;
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b0};
         end
      end
   end

   assign status.div_done = done_ff;

   // saturate the signed quotient
   always_comb begin
      res_zero  = 1'b0;
      res_value = '0;
      if (act_ff == ACT_EVALUATE) begin
         if (den_ff == '0) begin
            res_zero = 1'b1;
         end else if (neg_ff) begin
            res_value = (quo_ff > NUM_W'(32768)) ? 16'sh8000 : 16'(-quo_ff);
         end else begin
            res_value = (quo_ff > NUM_W'(32767)) ? 16'sh7fff : 16'(quo_ff);
         end
      end
   end

`ifndef ASSERT_OFF
   // divider completes only after being busy or on a zero sum
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(busy_ff) || $past(cmd.div_start)))
      else $error("divider done without work");
   // no accumulation while the divider runs
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !cmd.accumulate)
      else $error("accumulate during division");
   // table writes never overlap a rule walk
   assert property (@(posedge clock) disable iff (reset)
      cmd.do_write |-> !cmd.issue_read)
      else $error("write during rule walk");
`endif

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench of the fuzzy rule inference engine core
// loads membership, rule and singleton tables, runs evaluations under random
// stalls on both streams and checks every response word against an inline
// fixed-point predictor of the sugeno weighted average
// ----------------------------------------------------------------------------
module tb_top
   import frie_pkg::*;
();

   localparam int MAX_RULES  = 64;
   localparam int SETS       = 5;
   localparam int SINGLETONS = 9;
   localparam int MEM_DEPTH  = VARIABLES * SETS;
   localparam int LIMIT      = 2000000;

   typedef struct packed {
      logic [3:0]         kind;
      logic signed [15:0] slope_r;
      logic signed [15:0] slope_l;
      logic signed [15:0] pd;
      logic signed [15:0] pc;
      logic signed [15:0] pb;
      logic signed [15:0] pa;
      logic [5:0]         index;
      logic [1:0]         action;
   } req_word_t;

   typedef struct packed {
      logic        zero_weight;
      logic [15:0] control_value;
   } rsp_word_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic [111:0] req_tdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [15:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [6:0]   csr_data = '0;
   logic         csr_valid = 1'b0;
   logic         csr_ready;

   // predictor copy of the tables
   logic signed [15:0] mem_pts [MEM_DEPTH][4];
   logic signed [15:0] mem_sl [MEM_DEPTH];
   logic signed [15:0] mem_sr [MEM_DEPTH];
   logic [1:0]         mem_kind [MEM_DEPTH];
   logic [1:0]         rule_var [MAX_RULES][2];
   logic [2:0]         rule_set [MAX_RULES][2];
   logic [3:0]         rule_cons [MAX_RULES];
   logic signed [15:0] singleton [SINGLETON_DEPTH];
   int unsigned        rule_count = 50;

   rsp_word_t expected_rsp [$];
   int  errors = 0;
   int  n_eval = 0, n_zero = 0, n_rsp = 0;
   int  cycles = 0;
   bit  hold_rsp = 1'b0;

   fuzzy_rule_inference_engine_core dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_data(csr_data), .csr_valid(csr_valid), .csr_ready(csr_ready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("fuzzy_rule_inference_engine_core test failed");
         $finish;
      end
   end

   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // sloped degree, Q.17 product to Q1.15 clamped
   function automatic int unsigned slope_degree(logic signed [15:0] s, int signed diff);
      longint p;
      p = longint'(s) * longint'(diff);
      if (p <= 0) return 0;
      p = p >>> 2;
      if (p > 32768) p = 32768;
      return int'(p);
   endfunction

   function automatic int unsigned trap_degree(int signed x, int e);
      int signed a, b, c, d;
      a = int'(mem_pts[e][0]); b = int'(mem_pts[e][1]);
      c = int'(mem_pts[e][2]); d = int'(mem_pts[e][3]);
      case (mem_kind[e])
         KIND_LEFT: begin
            if (x <= a) return 32768;
            if (x >= b) return 0;
            return slope_degree(mem_sr[e], x - b);
         end
         KIND_RIGHT: begin
            if (x <= a) return 0;
            if (x >= b) return 32768;
            return slope_degree(mem_sl[e], x - a);
         end
         KIND_REGULAR: begin
            if (x <= a || x >= d) return 0;
            if (x >= b && x <= c) return 32768;
            if (x <= b) return slope_degree(mem_sl[e], x - a);
            if (x >= c) return slope_degree(mem_sr[e], x - d);
            return 0;
         end
         default: return 0;
      endcase
   endfunction

   // apply one word to the predicted tables and return its response
   function automatic rsp_word_t predict_control(req_word_t w);
      rsp_word_t res;
      longint num, den, q;
      int unsigned n, wt, m;
      int signed xv [4];
      int signed sv;
      res = '0;
      xv[0] = int'(w.pa); xv[1] = int'(w.pb); xv[2] = int'(w.pc); xv[3] = int'(w.pd);
      case (w.action)
         ACT_WR_MEMBER: if (w.index < MEM_DEPTH) begin
            mem_pts[w.index][0] = w.pa; mem_pts[w.index][1] = w.pb;
            mem_pts[w.index][2] = w.pc; mem_pts[w.index][3] = w.pd;
            mem_sl[w.index] = w.slope_l; mem_sr[w.index] = w.slope_r;
            mem_kind[w.index] = w.kind[1:0];
         end
         ACT_WR_RULE: if (w.index < MAX_RULES) begin
            rule_var[w.index][0] = w.pa[1:0]; rule_set[w.index][0] = w.pb[2:0];
            rule_var[w.index][1] = w.pc[1:0]; rule_set[w.index][1] = w.pd[2:0];
            rule_cons[w.index] = w.kind;
         end
         ACT_WR_SINGLETON: if (w.index < SINGLETONS) singleton[w.index] = w.pa;
         default: begin
            num = 0; den = 0;
            n = rule_count > MAX_RULES ? MAX_RULES : rule_count;
            for (int r = 0; r < n; r++) begin
               wt = 32768;
               for (int j = 0; j < 2; j++) begin
                  m = 0;
                  if (rule_set[r][j] < SETS)
                     m = trap_degree(xv[rule_var[r][j]],
                                     rule_var[r][j] * SETS + rule_set[r][j]);
                  if (j == 0 || m < wt) wt = m;
               end
               sv = rule_cons[r] < SINGLETONS ? int'(singleton[rule_cons[r]]) : 0;
               num += longint'(wt) * sv;
               den += longint'(wt);
            end
            if (den == 0) res.zero_weight = 1'b1;
            else begin
               q = num / den;
               if (q > 32767) q = 32767;
               if (q < -32768) q = -32768;
               res.control_value = q[15:0];
            end
         end
      endcase
      return res;
   endfunction

   // send one word and queue its expected response
   task automatic send_word(req_word_t w);
      int unsigned g;
      g = gap_len();
      if (g != 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tdata  <= 112'(w);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_rsp.push_back(predict_control(w));
      if (w.action == ACT_EVALUATE) n_eval++;
   endtask

   task automatic drain_idle();
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_rule_count(int unsigned v);
      drain_idle();
      csr_data  <= 7'(v);
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      rule_count = v;
   endtask

   // response receiver with random stalls
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         n_rsp++;
         if (expected_rsp.size() == 0) begin
            $error("response with nothing expected: %h %b", rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            rsp_word_t e;
            e = expected_rsp.pop_front();
            if (e.zero_weight) n_zero++;
            if (rsp_tdata !== e.control_value) begin
               $error("control_value expected %h actual %h", e.control_value, rsp_tdata);
               errors++;
            end
            if (rsp_tuser !== e.zero_weight) begin
               $error("zero_weight expected %b actual %b", e.zero_weight, rsp_tuser);
               errors++;
            end
         end
      end
      rsp_tready <= !hold_rsp && !reset && ($urandom_range(0, 99) < 70);
   end

   function automatic req_word_t mk_word(logic [1:0] act, logic [5:0] idx);
      req_word_t w;
      w = '0;
      w.action = act; w.index = idx;
      w.pa = 16'($urandom); w.pb = 16'($urandom);
      w.pc = 16'($urandom); w.pd = 16'($urandom);
      w.slope_l = 16'($urandom); w.slope_r = 16'($urandom); w.kind = 4'($urandom);
      return w;
   endfunction

   // well-formed trapezoid around a random center
   function automatic req_word_t mk_member(int e, logic [1:0] k);
      req_word_t w;
      int signed c0, wd;
      w = mk_word(ACT_WR_MEMBER, 6'(e));
      c0 = $urandom_range(0, 1600) - 800;
      wd = $urandom_range(1, 200);
      w.pa = 16'(c0 - 2 * wd); w.pb = 16'(c0 - wd);
      w.pc = 16'(c0 + wd); w.pd = 16'(c0 + 2 * wd);
      w.slope_l = 16'($urandom_range(1, 4000));
      w.slope_r = 16'(-int'($urandom_range(1, 4000)));
      w.kind = {2'b00, k};
      return w;
   endfunction

   function automatic req_word_t mk_rule(int r);
      req_word_t w;
      w = mk_word(ACT_WR_RULE, 6'(r));
      w.pa[1:0] = 2'($urandom);
      w.pb[2:0] = 3'($urandom_range(0, 9) < 9 ? $urandom_range(0, 4) : 7);
      w.pc[1:0] = 2'($urandom);
      w.pd[2:0] = 3'($urandom_range(0, 9) < 9 ? $urandom_range(0, 4) : 5);
      w.kind = 4'($urandom_range(0, 9) < 9 ? $urandom_range(0, 8) : $urandom_range(9, 15));
      return w;
   endfunction

   function automatic req_word_t mk_eval();
      req_word_t w;
      w = mk_word(ACT_EVALUATE, 6'($urandom));
      if ($urandom_range(0, 3) != 0) begin
         w.pa = 16'($urandom_range(0, 2000) - 1000);
         w.pb = 16'($urandom_range(0, 2000) - 1000);
         w.pc = 16'($urandom_range(0, 2000) - 1000);
         w.pd = 16'($urandom_range(0, 2000) - 1000);
      end
      return w;
   endfunction

   // fill every table entry that evaluations can read
   task automatic test_load_tables();
      for (int e = 0; e < MEM_DEPTH; e++) send_word(mk_member(e, 2'(e % 3)));
      for (int s = 0; s < SINGLETONS; s++) send_word(mk_word(ACT_WR_SINGLETON, 6'(s)));
      for (int r = 0; r < MAX_RULES; r++) send_word(mk_rule(r));
   endtask

   // extremes, odd kinds and ignored indexes
   task automatic test_directed();
      req_word_t w;
      w = mk_word(ACT_WR_MEMBER, 6'd63); send_word(w);          // ignored index
      w = mk_word(ACT_WR_MEMBER, 6'd20); send_word(w);
      w = mk_word(ACT_WR_RULE, 6'd63); send_word(w);            // rule beyond table in use
      w = mk_word(ACT_WR_SINGLETON, 6'd15); send_word(w);       // ignored singleton
      w = mk_word(ACT_WR_SINGLETON, 6'd0); w.pa = 16'sh7fff; send_word(w);
      w = mk_word(ACT_WR_SINGLETON, 6'd1); w.pa = 16'sh8000; send_word(w);
      w = mk_member(3, 2'd3); send_word(w);                     // kind code 3
      w = mk_member(0, KIND_LEFT); w.slope_l = 16'sh7fff; w.slope_r = 16'sh8000; send_word(w);
      w = mk_member(4, KIND_RIGHT); w.slope_l = 16'sh7fff; send_word(w);
      w = mk_word(ACT_EVALUATE, 6'd0);
      w.pa = 16'sh8000; w.pb = 16'sh8000; w.pc = 16'sh7fff; w.pd = 16'sh7fff; send_word(w);
      w.pa = 16'sh7fff; w.pb = 16'sh7fff; w.pc = 16'sh8000; w.pd = 16'sh8000; send_word(w);
      w = '0; w.action = ACT_EVALUATE; w.index = '1; w.kind = '1;
      w.slope_l = '1; w.slope_r = '1; send_word(w);
      for (int i = 0; i < 4; i++) send_word(mk_eval());
   endtask

   // rule count settings, extremes included
   task automatic test_rule_counts();
      int unsigned v [6] = '{0, 1, 64, 127, 65, 17};
      foreach (v[i]) begin
         write_rule_count(v[i]);
         for (int k = 0; k < 4; k++) send_word(mk_eval());
      end
   endtask

   // receiver stalls long while words keep coming
   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (600) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int k = 0; k < 10; k++) send_word(mk_eval());
      join
   endtask

   // mostly evaluations with table rewrites and noise between
   task automatic test_random();
      int unsigned r;
      for (int k = 0; k < 420; k++) begin
         r = $urandom_range(0, 99);
         if (k % 140 == 139) write_rule_count($urandom_range(0, 127));
         if (r < 65) send_word(mk_eval());
         else if (r < 75)
            send_word(mk_member($urandom_range(0, MEM_DEPTH - 1), 2'($urandom)));
         else if (r < 85) send_word(mk_rule($urandom_range(0, MAX_RULES - 1)));
         else if (r < 92)
            send_word(mk_word(ACT_WR_SINGLETON, 6'($urandom_range(0, 15))));
         else send_word(mk_word(ACT_WR_MEMBER, 6'($urandom_range(20, 63))));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_load_tables();
      test_directed();
      test_rule_counts();
      test_backpressure();
      write_rule_count(64);
      test_random();
      drain_idle();
      repeat (200) @(posedge clock);
      $display("covered %0d responses, %0d evaluations, %0d with zero weight",
               n_rsp, n_eval, n_zero);
      $display("rule counts 0 to 127 and a long receiver stall were exercised");
      if (errors == 0 && expected_rsp.size() == 0)
         $display("fuzzy_rule_inference_engine_core test passed");
      else
         $display("fuzzy_rule_inference_engine_core test failed");
      $finish;
   end

endmodule

/* fuzzy_rule_inference_engine_core.f */
rtl/frie_pkg.sv
rtl/frie_ram.sv
rtl/frie_ctrl.sv
rtl/frie_dp.sv
rtl/fuzzy_rule_inference_engine_core.sv
dv/tb_top.sv
